>>> rtl/lpcfd_pkg.sv
`timescale 1ns / 1ps

package lpcfd_pkg;

    // field sequence of one frame
    typedef logic [3:0] t_step;

    localparam t_step STEP_ENERGY = 4'd0;
    localparam t_step STEP_REPEAT = 4'd1;
    localparam t_step STEP_PERIOD = 4'd2;
    localparam t_step STEP_K0     = 4'd3;
    localparam t_step STEP_K1     = 4'd4;
    localparam t_step STEP_K2     = 4'd5;
    localparam t_step STEP_K3     = 4'd6;
    localparam t_step STEP_K6     = 4'd9;
    localparam t_step STEP_K7     = 4'd10;
    localparam t_step STEP_K9     = 4'd12;

    // special energy codes
    localparam logic [3:0] ENERGY_SILENT = 4'h0;
    localparam logic [3:0] ENERGY_STOP   = 4'hf;

    // fields completed by one word: at most three leave the parser
    localparam int SLOTS       = 3;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int QUEUE_DEPTH = 2;

    // result kinds
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_END   = 1'b1;

    typedef struct packed {
        logic       valid;
        t_step      step;
        logic [5:0] code;
        logic       emit;
    } t_event;

    typedef struct packed {
        t_event [SLOTS-1:0] ev;
    } t_batch;

    localparam logic [7:0] ENERGY_TAB [16] = '{
        8'h00, 8'h02, 8'h03, 8'h04, 8'h05, 8'h07, 8'h0a, 8'h0f,
        8'h14, 8'h20, 8'h29, 8'h39, 8'h51, 8'h72, 8'ha1, 8'hff};

    localparam logic [7:0] PERIOD_TAB [64] = '{
        8'd0,   8'd16,  8'd17,  8'd18,  8'd19,  8'd20,  8'd21,  8'd22,
        8'd23,  8'd24,  8'd25,  8'd26,  8'd27,  8'd28,  8'd29,  8'd30,
        8'd31,  8'd32,  8'd33,  8'd34,  8'd35,  8'd36,  8'd37,  8'd38,
        8'd39,  8'd40,  8'd41,  8'd42,  8'd43,  8'd45,  8'd47,  8'd49,
        8'd51,  8'd53,  8'd54,  8'd57,  8'd59,  8'd61,  8'd63,  8'd66,
        8'd69,  8'd71,  8'd73,  8'd77,  8'd79,  8'd81,  8'd85,  8'd87,
        8'd92,  8'd95,  8'd99,  8'd102, 8'd106, 8'd110, 8'd115, 8'd119,
        8'd123, 8'd128, 8'd133, 8'd138, 8'd143, 8'd149, 8'd154, 8'd160};

    localparam logic signed [15:0] KA_TAB [32] = '{
        -16'sd32064, -16'sd31872, -16'sd31808, -16'sd31680,
        -16'sd31552, -16'sd31424, -16'sd31232, -16'sd30848,
        -16'sd30592, -16'sd30336, -16'sd30016, -16'sd29696,
        -16'sd29376, -16'sd28928, -16'sd28480, -16'sd27968,
        -16'sd26368, -16'sd24256, -16'sd21632, -16'sd18368,
        -16'sd14528, -16'sd10048, -16'sd5184,  16'sd0,
        16'sd5184,   16'sd10048,  16'sd14528,  16'sd18368,
        16'sd21632,  16'sd24256,  16'sd26368,  16'sd27968};

    localparam logic signed [15:0] KB_TAB [32] = '{
        -16'sd20992, -16'sd19328, -16'sd17536, -16'sd15552,
        -16'sd13440, -16'sd11200, -16'sd8768,  -16'sd6272,
        -16'sd3712,  -16'sd1088,  16'sd1536,   16'sd4160,
        16'sd6720,   16'sd9216,   16'sd11584,  16'sd13824,
        16'sd15936,  16'sd17856,  16'sd19648,  16'sd21248,
        16'sd22656,  16'sd24000,  16'sd25152,  16'sd26176,
        16'sd27072,  16'sd27840,  16'sd28544,  16'sd29120,
        16'sd29632,  16'sd30080,  16'sd30464,  16'sd32384};

    // k2..k9; the 3-bit coefficients use the first eight entries
    localparam logic signed [7:0] KN_TAB [8][16] = '{
        '{-8'sd110, -8'sd97, -8'sd83, -8'sd70, -8'sd56, -8'sd43, -8'sd29, -8'sd16,
          -8'sd2, 8'sd11, 8'sd25, 8'sd38, 8'sd52, 8'sd65, 8'sd79, 8'sd92},
        '{-8'sd82, -8'sd68, -8'sd54, -8'sd40, -8'sd26, -8'sd12, 8'sd1, 8'sd15,
          8'sd29, 8'sd43, 8'sd57, 8'sd71, 8'sd85, 8'sd99, 8'sd113, 8'sd126},
        '{-8'sd82, -8'sd70, -8'sd59, -8'sd47, -8'sd35, -8'sd24, -8'sd12, -8'sd1,
          8'sd11, 8'sd23, 8'sd34, 8'sd46, 8'sd57, 8'sd69, 8'sd81, 8'sd92},
        '{-8'sd64, -8'sd53, -8'sd42, -8'sd31, -8'sd20, -8'sd9, 8'sd3, 8'sd14,
          8'sd25, 8'sd36, 8'sd47, 8'sd58, 8'sd69, 8'sd80, 8'sd91, 8'sd102},
        '{-8'sd77, -8'sd65, -8'sd53, -8'sd41, -8'sd29, -8'sd17, -8'sd5, 8'sd7,
          8'sd19, 8'sd31, 8'sd43, 8'sd55, 8'sd67, 8'sd79, 8'sd90, 8'sd102},
        '{-8'sd64, -8'sd40, -8'sd16, 8'sd7, 8'sd31, 8'sd55, 8'sd79, 8'sd102,
          8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0},
        '{-8'sd64, -8'sd44, -8'sd24, -8'sd4, 8'sd16, 8'sd37, 8'sd57, 8'sd77,
          8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0},
        '{-8'sd51, -8'sd33, -8'sd15, 8'sd4, 8'sd22, 8'sd32, 8'sd59, 8'sd77,
          8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0}};

    // number of bits in the field expected at a step
    function automatic logic [2:0] field_width(input t_step s);
        logic [2:0] w;
        case (s) inside
            STEP_REPEAT:       w = 3'd1;
            STEP_PERIOD:       w = 3'd6;
            STEP_K0, STEP_K1:  w = 3'd5;
            [STEP_K7:STEP_K9]: w = 3'd3;
            default:           w = 3'd4;
        endcase
        return w;
    endfunction

endpackage

>>> rtl/lpcfd_front.sv
`timescale 1ns / 1ps

module lpcfd_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [7:0]            i_stream_byte,
    input  logic                  i_q_full,
    output logic                  o_stall,
    output logic                  o_push,
    output lpcfd_pkg::t_batch     o_batch
);

    lpcfd_pkg::t_step r_step, n_step;
    logic [2:0]       r_bits, n_bits;
    logic [5:0]       r_accum, n_accum;
    logic             r_repeat, n_repeat;
    logic             r_voiced, n_voiced;
    logic             accept;
    logic             any_event;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign o_push  = accept && any_event;

    // split one word into completed fields, least significant bit first
    always_comb begin : p_parse
        lpcfd_pkg::t_step        step;
        logic [2:0]              bits;
        logic [5:0]              acc;
        logic                    rep;
        logic                    voi;
        logic                    stopped;
        logic [lpcfd_pkg::SLOT_W-1:0] n;
        lpcfd_pkg::t_event       ev;
        lpcfd_pkg::t_batch       b;

        step    = (r_step > lpcfd_pkg::STEP_K9) ? lpcfd_pkg::STEP_ENERGY : r_step;
        bits    = r_bits;
        acc     = r_accum;
        rep     = r_repeat;
        voi     = r_voiced;
        stopped = 1'b0;
        n       = '0;
        b       = '0;
        ev      = '0;

        for (int i = 0; i < 8; i++) begin
            if (!stopped) begin
                acc  = {acc[4:0], i_stream_byte[i]};
                bits = bits + 3'd1;
                if (bits >= lpcfd_pkg::field_width(step)) begin
                    ev.valid = 1'b1;
                    ev.step  = step;
                    ev.code  = acc;
                    ev.emit  = 1'b0;
                    acc      = '0;
                    bits     = '0;
                    case (step) inside
                        lpcfd_pkg::STEP_REPEAT: begin
                            // only steers the parse, the back end never needs it
                            rep      = ev.code[0];
                            ev.valid = 1'b0;
                            step     = lpcfd_pkg::STEP_PERIOD;
                        end
                        lpcfd_pkg::STEP_PERIOD: begin
                            voi = (ev.code != 6'd0);
                            if (rep) begin
                                ev.emit = 1'b1;
                                step    = lpcfd_pkg::STEP_ENERGY;
                            end else begin
                                step = lpcfd_pkg::STEP_K0;
                            end
                        end
                        [lpcfd_pkg::STEP_K0:lpcfd_pkg::STEP_K9]: begin
                            // unvoiced frames end after k3
                            if ((step == lpcfd_pkg::STEP_K3 && !voi) ||
                                step == lpcfd_pkg::STEP_K9) begin
                                ev.emit = 1'b1;
                                step    = lpcfd_pkg::STEP_ENERGY;
                            end else begin
                                step = step + 4'd1;
                            end
                        end
                        default: begin
                            if (ev.code[3:0] == lpcfd_pkg::ENERGY_SILENT) begin
                                ev.emit = 1'b1;
                            end else if (ev.code[3:0] == lpcfd_pkg::ENERGY_STOP) begin
                                // end of word: drop the rest of this word
                                ev.emit = 1'b1;
                                rep     = 1'b0;
                                voi     = 1'b0;
                                stopped = 1'b1;
                            end else begin
                                step = lpcfd_pkg::STEP_REPEAT;
                            end
                        end
                    endcase
                    if (ev.valid) begin
                        b.ev[n] = ev;
                        n       = n + 1'b1;
                    end
                end
            end
        end

        n_step    = step;
        n_bits    = bits;
        n_accum   = acc;
        n_repeat  = rep;
        n_voiced  = voi;
        o_batch   = b;
        any_event = b.ev[0].valid;
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= lpcfd_pkg::STEP_ENERGY;
            r_bits   <= '0;
            r_accum  <= '0;
            r_repeat <= 1'b0;
            r_voiced <= 1'b0;
        end else if (accept) begin
            r_step   <= n_step;
            r_bits   <= n_bits;
            r_accum  <= n_accum;
            r_repeat <= n_repeat;
            r_voiced <= n_voiced;
        end
    end

endmodule

>>> rtl/lpcfd_queue.sv
`timescale 1ns / 1ps

module lpcfd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lpcfd_pkg::t_batch i_data,
    input  logic              i_pop,
    output lpcfd_pkg::t_batch o_data,
    output logic              o_full,
    output logic              o_empty
);

    localparam int PTR_W = $clog2(lpcfd_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(lpcfd_pkg::QUEUE_DEPTH + 1);

    lpcfd_pkg::t_batch r_mem [lpcfd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_count, n_count;

    assign o_data  = r_mem[r_rd];
    assign o_full  = (r_count == CNT_W'(lpcfd_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);

    // occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

>>> rtl/lpcfd_back.sv
`timescale 1ns / 1ps

module lpcfd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_batch_valid,
    input  lpcfd_pkg::t_batch   i_batch,
    output logic                o_pop,
    input  logic                i_stall,
    output logic                o_valid,
    output logic                o_result_kind,
    output logic                o_last_in_byte,
    output logic [7:0]          o_energy_value,
    output logic [7:0]          o_pitch_period,
    output logic signed [15:0]  o_refl_first,
    output logic signed [15:0]  o_refl_second,
    output logic [63:0]         o_refl_rest_packed
);

    // frame registers
    logic [7:0]        r_energy, n_energy;
    logic [7:0]        r_period, n_period;
    logic signed [15:0] r_ka, n_ka;
    logic signed [15:0] r_kb, n_kb;
    logic signed [7:0] r_kn [8];
    logic signed [7:0] n_kn [8];
    logic [lpcfd_pkg::SLOT_W-1:0] r_idx;

    // output register
    logic              r_out_valid;
    logic              r_kind;
    logic              r_last;
    logic [7:0]        r_out_energy;
    logic [7:0]        r_out_period;
    logic signed [15:0] r_out_ka;
    logic signed [15:0] r_out_kb;
    logic [63:0]       r_out_rest;

    logic              emit_seen;
    logic              emit_kind;
    logic [lpcfd_pkg::SLOT_W-1:0] emit_pos;
    logic              later_any;
    logic              later_emit;
    logic              out_free;
    logic              go;
    logic [63:0]       rest_packed;

    // apply fields from the current slot up to and including the next frame end
    always_comb begin : p_apply
        lpcfd_pkg::t_event ev;
        logic [2:0]        ki;

        n_energy   = r_energy;
        n_period   = r_period;
        n_ka       = r_ka;
        n_kb       = r_kb;
        n_kn       = r_kn;
        emit_seen  = 1'b0;
        emit_kind  = lpcfd_pkg::KIND_FRAME;
        emit_pos   = '0;
        later_any  = 1'b0;
        later_emit = 1'b0;
        ev         = '0;
        ki         = '0;

        for (int j = 0; j < lpcfd_pkg::SLOTS; j++) begin
            ev = i_batch.ev[j];
            if (ev.valid && (lpcfd_pkg::SLOT_W'(j) >= r_idx)) begin
                if (emit_seen) begin
                    later_any = 1'b1;
                    if (ev.emit) begin
                        later_emit = 1'b1;
                    end
                end else begin
                    case (ev.step) inside
                        lpcfd_pkg::STEP_REPEAT: begin
                        end
                        lpcfd_pkg::STEP_PERIOD: begin
                            n_period = lpcfd_pkg::PERIOD_TAB[ev.code];
                        end
                        lpcfd_pkg::STEP_K0: begin
                            n_ka = lpcfd_pkg::KA_TAB[ev.code[4:0]];
                        end
                        lpcfd_pkg::STEP_K1: begin
                            n_kb = lpcfd_pkg::KB_TAB[ev.code[4:0]];
                        end
                        [lpcfd_pkg::STEP_K2:lpcfd_pkg::STEP_K9]: begin
                            ki       = 3'(ev.step - lpcfd_pkg::STEP_K2);
                            n_kn[ki] = lpcfd_pkg::KN_TAB[ki][ev.code[3:0]];
                        end
                        default: begin
                            if (ev.code[3:0] == lpcfd_pkg::ENERGY_STOP) begin
                                // end of word clears the whole frame
                                n_energy  = '0;
                                n_period  = '0;
                                n_ka      = '0;
                                n_kb      = '0;
                                for (int m = 0; m < 8; m++) begin
                                    n_kn[m] = '0;
                                end
                                emit_kind = lpcfd_pkg::KIND_END;
                            end else begin
                                n_energy = lpcfd_pkg::ENERGY_TAB[ev.code[3:0]];
                            end
                        end
                    endcase
                    if (ev.emit) begin
                        emit_seen = 1'b1;
                        emit_pos  = lpcfd_pkg::SLOT_W'(j);
                    end
                end
            end
        end

        for (int m = 0; m < 8; m++) begin
            rest_packed[8*m +: 8] = n_kn[m];
        end
    end

    assign out_free = !r_out_valid || !i_stall;
    assign go       = i_batch_valid && (!emit_seen || out_free);
    assign o_pop    = go && !(emit_seen && later_any);

    // frame state and slot pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_energy <= '0;
            r_period <= '0;
            r_ka     <= '0;
            r_kb     <= '0;
            for (int m = 0; m < 8; m++) begin
                r_kn[m] <= '0;
            end
            r_idx    <= '0;
        end else if (go) begin
            r_energy <= n_energy;
            r_period <= n_period;
            r_ka     <= n_ka;
            r_kb     <= n_kb;
            r_kn     <= n_kn;
            if (o_pop) begin
                r_idx <= '0;
            end else begin
                r_idx <= emit_pos + 1'b1;
            end
        end
    end

    // result handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go && emit_seen) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (go && emit_seen) begin
            r_kind       <= emit_kind;
            r_last       <= !later_emit;
            r_out_energy <= n_energy;
            r_out_period <= n_period;
            r_out_ka     <= n_ka;
            r_out_kb     <= n_kb;
            r_out_rest   <= rest_packed;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_result_kind      = r_kind;
    assign o_last_in_byte     = r_last;
    assign o_energy_value     = r_out_energy;
    assign o_pitch_period     = r_out_period;
    assign o_refl_first       = r_out_ka;
    assign o_refl_second      = r_out_kb;
    assign o_refl_rest_packed = r_out_rest;

endmodule

>>> rtl/lpc_frame_bitstream_decoder_unit.sv
`timescale 1ns / 1ps

// LPC speech frame decoder. Compressed speech enters one byte per word on the
// input channel (i_valid / o_stall, i_stream_byte); a word is taken at a clock
// edge with i_valid high and o_stall low. Bits are used least significant
// first and may continue a field started in an earlier word.
// Decoded frames and end-of-word markers leave on the output channel
// (o_valid / i_stall); o_last_in_byte flags the final result caused by an
// input word, so a word gives zero, one or two results.
// With the queue empty and the output free, the fields of a word pass through
// a queue entry into the output register, where the result becomes valid.
// Throughput: the bit parser takes one word per cycle while the queue is not
// full; the frame register unit behind a two-entry queue handles each result
// of a word in its own step, and a further step for fields after the last one.
// The output register reloads in the cycle its word is taken, so no bubble
// is needed between results. While i_stall is high the result holds; the
// queue keeps accepting words until it fills, then o_stall rises.
// Synchronous reset (i_rst_n low) clears the parser, the queue and all frame
// registers to zero; the next word is parsed as an energy field.

module lpc_frame_bitstream_decoder_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_stream_byte,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_result_kind,
    output logic               o_last_in_byte,
    output logic [7:0]         o_energy_value,
    output logic [7:0]         o_pitch_period,
    output logic signed [15:0] o_refl_first,
    output logic signed [15:0] o_refl_second,
    output logic [63:0]        o_refl_rest_packed
);

    lpcfd_pkg::t_batch push_batch;
    lpcfd_pkg::t_batch head_batch;
    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_empty;

    // bit parser
    lpcfd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_stream_byte (i_stream_byte),
        .i_q_full      (q_full),
        .o_stall       (o_stall),
        .o_push        (push),
        .o_batch       (push_batch)
    );

    // field queue
    lpcfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_batch),
        .i_pop   (pop),
        .o_data  (head_batch),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // frame registers and result output
    lpcfd_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_batch_valid      (!q_empty),
        .i_batch            (head_batch),
        .o_pop              (pop),
        .i_stall            (i_stall),
        .o_valid            (o_valid),
        .o_result_kind      (o_result_kind),
        .o_last_in_byte     (o_last_in_byte),
        .o_energy_value     (o_energy_value),
        .o_pitch_period     (o_pitch_period),
        .o_refl_first       (o_refl_first),
        .o_refl_second      (o_refl_second),
        .o_refl_rest_packed (o_refl_rest_packed)
    );

endmodule

>>> bench/lpc_frame_decode_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the LPC frame decoder, predicts the results of every
// accepted stream word and compares them in order with the accepted results.
module lpc_frame_decode_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_word_valid,
    input  logic               i_word_stall,
    input  logic [7:0]         i_stream_byte,
    input  logic               i_res_valid,
    input  logic               i_res_stall,
    input  logic               i_result_kind,
    input  logic               i_last_in_byte,
    input  logic [7:0]         i_energy_value,
    input  logic [7:0]         i_pitch_period,
    input  logic signed [15:0] i_refl_first,
    input  logic signed [15:0] i_refl_second,
    input  logic [63:0]        i_refl_rest_packed,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic               kind;
        logic               last;
        logic [7:0]         energy;
        logic [7:0]         period;
        logic signed [15:0] k0;
        logic signed [15:0] k1;
        logic [63:0]        rest;
    } t_frame_res;

    t_frame_res expected_frames[$];
    int         fail_cnt = 0;

    // parser and frame register copy
    lpcfd_pkg::t_step   step_r;
    logic [2:0]         bits_r;
    logic [5:0]         acc_r;
    logic               rep_r;
    logic [7:0]         energy_r;
    logic [7:0]         period_r;
    logic signed [15:0] ka_r;
    logic signed [15:0] kb_r;
    logic [7:0]         kn_r [8];

    function automatic logic [2:0] bits_for_step(input lpcfd_pkg::t_step s);
        if (s == lpcfd_pkg::STEP_REPEAT)
            return 3'd1;
        if (s == lpcfd_pkg::STEP_PERIOD)
            return 3'd6;
        if (s == lpcfd_pkg::STEP_K0 || s == lpcfd_pkg::STEP_K1)
            return 3'd5;
        if (s >= lpcfd_pkg::STEP_K7 && s <= lpcfd_pkg::STEP_K9)
            return 3'd3;
        return 3'd4;
    endfunction

    task automatic clear_frame_state();
        step_r   = lpcfd_pkg::STEP_ENERGY;
        bits_r   = '0;
        acc_r    = '0;
        rep_r    = 1'b0;
        energy_r = '0;
        period_r = '0;
        ka_r     = '0;
        kb_r     = '0;
        for (int j = 0; j < 8; j++)
            kn_r[j] = '0;
    endtask

    // current frame registers as one result; an end marker carries zeros
    function automatic t_frame_res frame_snapshot(input logic kind);
        t_frame_res r;
        r = '0;
        r.kind = kind;
        if (kind == lpcfd_pkg::KIND_FRAME) begin
            r.energy = energy_r;
            r.period = period_r;
            r.k0     = ka_r;
            r.k1     = kb_r;
            for (int j = 0; j < 8; j++)
                r.rest[8*j +: 8] = kn_r[j];
        end
        return r;
    endfunction

    // run the bits of one word through the field parser, LSB first
    task automatic decode_stream_byte(input logic [7:0] b);
        t_frame_res res [2];
        int         n;
        int         i;
        logic [5:0] v;
        logic [2:0] idx;
        bit         stopped;
        n       = 0;
        stopped = 1'b0;
        if (step_r > lpcfd_pkg::STEP_K9)
            step_r = lpcfd_pkg::STEP_ENERGY;
        for (i = 0; i < 8 && !stopped; i++) begin
            acc_r  = {acc_r[4:0], b[i]};
            bits_r = bits_r + 3'd1;
            if (bits_r >= bits_for_step(step_r)) begin
                v      = acc_r;
                acc_r  = '0;
                bits_r = '0;
                case (step_r)
                    lpcfd_pkg::STEP_ENERGY: begin
                        if (v[3:0] == lpcfd_pkg::ENERGY_SILENT) begin
                            energy_r = '0;
                            if (n < 2) begin
                                res[n] = frame_snapshot(lpcfd_pkg::KIND_FRAME);
                                n++;
                            end
                        end else if (v[3:0] == lpcfd_pkg::ENERGY_STOP) begin
                            clear_frame_state();
                            if (n < 2) begin
                                res[n] = frame_snapshot(lpcfd_pkg::KIND_END);
                                n++;
                            end
                            stopped = 1'b1;
                        end else begin
                            energy_r = lpcfd_pkg::ENERGY_TAB[v[3:0]];
                            step_r   = lpcfd_pkg::STEP_REPEAT;
                        end
                    end
                    lpcfd_pkg::STEP_REPEAT: begin
                        rep_r  = v[0];
                        step_r = lpcfd_pkg::STEP_PERIOD;
                    end
                    lpcfd_pkg::STEP_PERIOD: begin
                        period_r = lpcfd_pkg::PERIOD_TAB[v];
                        if (rep_r) begin
                            step_r = lpcfd_pkg::STEP_ENERGY;
                            if (n < 2) begin
                                res[n] = frame_snapshot(lpcfd_pkg::KIND_FRAME);
                                n++;
                            end
                        end else begin
                            step_r = lpcfd_pkg::STEP_K0;
                        end
                    end
                    lpcfd_pkg::STEP_K0: begin
                        ka_r   = lpcfd_pkg::KA_TAB[v[4:0]];
                        step_r = lpcfd_pkg::STEP_K1;
                    end
                    lpcfd_pkg::STEP_K1: begin
                        kb_r   = lpcfd_pkg::KB_TAB[v[4:0]];
                        step_r = lpcfd_pkg::STEP_K2;
                    end
                    default: begin
                        idx       = 3'(step_r - lpcfd_pkg::STEP_K2);
                        kn_r[idx] = lpcfd_pkg::KN_TAB[idx][v[3:0]];
                        // unvoiced frames stop after k3
                        if ((step_r == lpcfd_pkg::STEP_K3 && period_r == 8'd0) ||
                            step_r == lpcfd_pkg::STEP_K9) begin
                            step_r = lpcfd_pkg::STEP_ENERGY;
                            if (n < 2) begin
                                res[n] = frame_snapshot(lpcfd_pkg::KIND_FRAME);
                                n++;
                            end
                        end else begin
                            step_r = step_r + 4'd1;
                        end
                    end
                endcase
            end
        end
        if (n > 0)
            res[n-1].last = 1'b1;
        for (i = 0; i < n; i++)
            expected_frames.push_back(res[i]);
    endtask

    task automatic cmp_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t ERROR %s: expected %0h actual %0h", $time, name, exp_v, act_v);
            fail_cnt++;
        end
    endtask

    task automatic check_result();
        t_frame_res exp_r;
        if (expected_frames.size() == 0) begin
            $display("%0t ERROR unexpected result: expected none actual kind %0b energy %0h",
                     $time, i_result_kind, i_energy_value);
            fail_cnt++;
        end else begin
            exp_r = expected_frames.pop_front();
            cmp_field("result_kind", 64'(exp_r.kind), 64'(i_result_kind));
            cmp_field("last_in_byte", 64'(exp_r.last), 64'(i_last_in_byte));
            cmp_field("energy_value", 64'(exp_r.energy), 64'(i_energy_value));
            cmp_field("pitch_period", 64'(exp_r.period), 64'(i_pitch_period));
            cmp_field("refl_first", 64'(exp_r.k0), 64'(i_refl_first));
            cmp_field("refl_second", 64'(exp_r.k1), 64'(i_refl_second));
            cmp_field("refl_rest_packed", exp_r.rest, i_refl_rest_packed);
        end
    endtask

    // sample both channels at the edge; words are predicted before results pop
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_frame_state();
            expected_frames.delete();
        end else begin
            if (i_word_valid && !i_word_stall)
                decode_stream_byte(i_stream_byte);
            if (i_res_valid && !i_res_stall)
                check_result();
        end
        o_pending    <= expected_frames.size();
        o_fail_count <= fail_cnt;
    end

endmodule

>>> bench/lpc_frame_bitstream_decoder_unit_tb.sv
`timescale 1ns / 1ps

module lpc_frame_bitstream_decoder_unit_tb;

    localparam int RANDOM_WORDS = 850;
    localparam int HOLD_AT_WORD = 200;
    localparam int HOLD_CYCLES  = 300;

    // bits per coefficient field, k0..k9
    localparam int KW [10] = '{5, 5, 4, 4, 4, 4, 4, 3, 3, 3};

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               tx_valid = 1'b0;
    logic [7:0]         tx_byte  = 8'h00;
    logic               rx_stall = 1'b0;
    logic               dut_stall;
    logic               res_valid;
    logic               res_kind;
    logic               res_last;
    logic [7:0]         res_energy;
    logic [7:0]         res_period;
    logic signed [15:0] res_k0;
    logic signed [15:0] res_k1;
    logic [63:0]        res_rest;
    int                 fail_count;
    int                 pending;

    int  words_sent = 0;
    bit  tx_quiet   = 1'b0;
    bit  hold_req   = 1'b0;
    bit  stream_bits[$];

    lpc_frame_bitstream_decoder_unit u_dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_valid            (tx_valid),
        .o_stall            (dut_stall),
        .i_stream_byte      (tx_byte),
        .o_valid            (res_valid),
        .i_stall            (rx_stall),
        .o_result_kind      (res_kind),
        .o_last_in_byte     (res_last),
        .o_energy_value     (res_energy),
        .o_pitch_period     (res_period),
        .o_refl_first       (res_k0),
        .o_refl_second      (res_k1),
        .o_refl_rest_packed (res_rest)
    );

    lpc_frame_decode_checker u_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_word_valid       (tx_valid),
        .i_word_stall       (dut_stall),
        .i_stream_byte      (tx_byte),
        .i_res_valid        (res_valid),
        .i_res_stall        (rx_stall),
        .i_result_kind      (res_kind),
        .i_last_in_byte     (res_last),
        .i_energy_value     (res_energy),
        .i_pitch_period     (res_period),
        .i_refl_first       (res_k0),
        .i_refl_second      (res_k1),
        .i_refl_rest_packed (res_rest),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    // offer one word after a random gap and wait until it is taken
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (words_sent % 40 == 0)
            tx_quiet = ($urandom_range(0, 3) == 0);
        gap = tx_quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            tx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tx_valid <= 1'b1;
        tx_byte  <= b;
        do @(posedge clk); while (dut_stall);
        words_sent++;
        if (words_sent == HOLD_AT_WORD)
            hold_req = 1'b1;
    endtask

    // fields go out MSB first into the LSB-first bit stream
    task automatic put_field(input int val, input int w);
        for (int b = w - 1; b >= 0; b--)
            stream_bits.push_back(val[b]);
    endtask

    task automatic pad_to_byte();
        while (stream_bits.size() % 8 != 0)
            stream_bits.push_back(1'($urandom_range(0, 1)));
    endtask

    task automatic flush_bytes();
        logic [7:0] b;
        while (stream_bits.size() >= 8) begin
            for (int k = 0; k < 8; k++)
                b[k] = stream_bits.pop_front();
            send_byte(b);
        end
    endtask

    task automatic put_frame(input int e, input int rep, input int per, input int kc [10]);
        put_field(e, 4);
        if (e == lpcfd_pkg::ENERGY_SILENT)
            return;
        // the block drops the rest of the word after a stop code
        if (e == lpcfd_pkg::ENERGY_STOP) begin
            pad_to_byte();
            return;
        end
        put_field(rep, 1);
        put_field(per, 6);
        if (rep != 0)
            return;
        for (int j = 0; j < 4; j++)
            put_field(kc[j], KW[j]);
        if (per != 0)
            for (int j = 4; j < 10; j++)
                put_field(kc[j], KW[j]);
    endtask

    task automatic random_frame();
        int kc [10];
        int sel;
        int e;
        sel = $urandom_range(0, 19);
        if (sel < 2)
            e = int'(lpcfd_pkg::ENERGY_SILENT);
        else if (sel == 2)
            e = int'(lpcfd_pkg::ENERGY_STOP);
        else
            e = $urandom_range(1, 14);
        for (int j = 0; j < 10; j++)
            kc[j] = $urandom_range(0, (1 << KW[j]) - 1);
        put_frame(e, int'($urandom_range(0, 3) == 0),
                  ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 63)), kc);
    endtask

    // result side: random stalls, quiet stretches and one long hold-off
    initial begin
        int  gap;
        int  n_res;
        bit  rx_quiet;
        bit  hold_done;
        n_res     = 0;
        rx_quiet  = 1'b0;
        hold_done = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (n_res % 40 == 0)
                rx_quiet = ($urandom_range(0, 3) == 0);
            if (hold_req && !hold_done) begin
                gap       = HOLD_CYCLES;
                hold_done = 1'b1;
            end else begin
                gap = rx_quiet ? 0 : $urandom_range(0, 12);
            end
            if (gap > 0) begin
                rx_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            rx_stall <= 1'b0;
            do @(posedge clk); while (!(res_valid && !rx_stall));
            n_res++;
        end
    end

    // stimulus and verdict
    initial begin
        int kmax [10];
        int kmin [10];
        kmax = '{31, 31, 15, 15, 15, 15, 15, 7, 7, 7};
        kmin = '{default: 0};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: stop, extreme codes, repeat, unvoiced, silence
        put_frame(int'(lpcfd_pkg::ENERGY_STOP), 0, 0, kmin);
        put_frame(14, 0, 63, kmax);
        put_frame(1, 0, 1, kmin);
        put_frame(7, 1, 0, kmin);
        put_frame(9, 0, 0, kmax);
        put_frame(int'(lpcfd_pkg::ENERGY_SILENT), 0, 0, kmin);
        put_frame(int'(lpcfd_pkg::ENERGY_SILENT), 0, 0, kmin);
        put_frame(13, 1, 63, kmax);
        put_frame(int'(lpcfd_pkg::ENERGY_STOP), 0, 0, kmin);
        flush_bytes();
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(8'haa);
        send_byte(8'h55);

        // random: mostly well-formed frames, some raw noise then a resync
        while (words_sent < RANDOM_WORDS) begin
            if ($urandom_range(0, 99) < 85) begin
                random_frame();
                flush_bytes();
            end else begin
                pad_to_byte();
                flush_bytes();
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
                // all-ones words end any frame and land on a stop code
                repeat (7) send_byte(8'hff);
            end
        end
        pad_to_byte();
        flush_bytes();
        tx_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
